/* hdl/dd_pkg.sv */
// ---------------------------------------------------------------------------
// dd_pkg: shared types and constants of the deadlock detector
// Field widths, operation codes, microcode word layout and the control
// program that walks the allocation and request matrices.
// ---------------------------------------------------------------------------
`default_nettype none

package dd_pkg;

	localparam int MAX_PROCESSES = 16;
	localparam int MAX_RESOURCES = 8;
	localparam int AMOUNT_WIDTH  = 16;

	// item and result field widths
	localparam int OP_W       = 2;
	localparam int PIDX_FLD_W = 4;
	localparam int RIDX_FLD_W = 3;
	localparam int AMT_FLD_W  = 16;
	localparam int MASK_W     = 16;
	localparam int DEAD_W     = 5;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int PCNT_W     = 5;
	localparam int RCNT_W     = 4;

	// internal widths
	localparam int P_IDX_W = $clog2(MAX_PROCESSES);
	localparam int R_IDX_W = $clog2(MAX_RESOURCES);
	localparam int NP_W    = $clog2(MAX_PROCESSES + 1);
	localparam int NR_W    = $clog2(MAX_RESOURCES + 1);
	localparam int ADDR_W  = P_IDX_W + R_IDX_W;
	localparam int DEPTH   = MAX_PROCESSES * MAX_RESOURCES;
	localparam int STEP_W  = 4;

	typedef enum logic [OP_W-1:0] {
		OP_WR_AVAIL = 2'd0,
		OP_WR_ALLOC = 2'd1,
		OP_WR_REQ   = 2'd2,
		OP_RUN      = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROCESS_COUNT  = 1'b0,
		CFG_RESOURCE_COUNT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		C_NEVER      = 3'd0,
		C_NP_ZERO    = 3'd1,
		C_FIN_P      = 3'd2,
		C_NR_ZERO    = 3'd3,
		C_NOT_R_LAST = 3'd4,
		C_NOT_FITS   = 3'd5,
		C_NOT_P_LAST = 3'd6,
		C_CHANGED    = 3'd7
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	// program addresses
	localparam step_t ST_INIT     = 4'd0;
	localparam step_t ST_PROC     = 4'd1;
	localparam step_t ST_CHKZ     = 4'd2;
	localparam step_t ST_RDCHK    = 4'd3;
	localparam step_t ST_CHK      = 4'd4;
	localparam step_t ST_DECIDE   = 4'd5;
	localparam step_t ST_RELZ     = 4'd6;
	localparam step_t ST_RDREL    = 4'd7;
	localparam step_t ST_REL      = 4'd8;
	localparam step_t ST_MARK     = 4'd9;
	localparam step_t ST_NEXT     = 4'd10;
	localparam step_t ST_PASS_END = 4'd11;
	localparam step_t ST_DONE     = 4'd12;

	typedef struct packed {
		logic  run_init;
		logic  pass_start;
		logic  proc_start;
		logic  r_clr;
		logic  chk;
		logic  rel;
		logic  mark;
		logic  p_inc;
		logic  done;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic run_init;
		logic pass_start;
		logic proc_start;
		logic r_clr;
		logic chk;
		logic rel;
		logic mark;
		logic p_inc;
		logic done;
	} ctrl_t;

	typedef struct packed {
		logic              np_zero;
		logic              nr_zero;
		logic              fin_p;
		logic              r_last;
		logic              p_last;
		logic              fits;
		logic              changed;
		logic [MASK_W-1:0] mask;
		logic [DEAD_W-1:0] dead;
	} stat_t;

	typedef struct packed {
		logic                    en_avail;
		logic                    en_alloc;
		logic                    en_req;
		logic [P_IDX_W-1:0]      p;
		logic [R_IDX_W-1:0]      r;
		logic [AMOUNT_WIDTH-1:0] amt;
	} load_t;

	// control program: one word per step, jump to target when cond holds
	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		w = '0;
		case (step)
			ST_INIT: begin
				w.run_init   = 1'b1;
				w.pass_start = 1'b1;
				w.cond       = C_NP_ZERO;
				w.target     = ST_PASS_END;
			end
			ST_PROC: begin
				w.proc_start = 1'b1;
				w.cond       = C_FIN_P;
				w.target     = ST_NEXT;
			end
			ST_CHKZ: begin
				w.cond   = C_NR_ZERO;
				w.target = ST_DECIDE;
			end
			ST_RDCHK: begin
				w.cond = C_NEVER;
			end
			ST_CHK: begin
				w.chk    = 1'b1;
				w.cond   = C_NOT_R_LAST;
				w.target = ST_RDCHK;
			end
			ST_DECIDE: begin
				w.r_clr  = 1'b1;
				w.cond   = C_NOT_FITS;
				w.target = ST_NEXT;
			end
			ST_RELZ: begin
				w.cond   = C_NR_ZERO;
				w.target = ST_MARK;
			end
			ST_RDREL: begin
				w.cond = C_NEVER;
			end
			ST_REL: begin
				w.rel    = 1'b1;
				w.cond   = C_NOT_R_LAST;
				w.target = ST_RDREL;
			end
			ST_MARK: begin
				w.mark = 1'b1;
			end
			ST_NEXT: begin
				w.p_inc  = 1'b1;
				w.cond   = C_NOT_P_LAST;
				w.target = ST_PROC;
			end
			ST_PASS_END: begin
				w.pass_start = 1'b1;
				w.cond       = C_CHANGED;
				w.target     = ST_PROC;
			end
			ST_DONE: begin
				w.done = 1'b1;
			end
			default: begin
				w.done = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* hdl/dd_in_if.sv */
// ---------------------------------------------------------------------------
// dd_in_if: item channel of the deadlock detector
// Valid/ready channel carrying one load or run item per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface dd_in_if;
	logic                           valid;
	logic                           ready;
	logic [dd_pkg::OP_W-1:0]        operation;
	logic [dd_pkg::PIDX_FLD_W-1:0]  process_index;
	logic [dd_pkg::RIDX_FLD_W-1:0]  resource_index;
	logic [dd_pkg::AMT_FLD_W-1:0]   amount;

	modport source (
		output valid, operation, process_index, resource_index, amount,
		input  ready
	);
	modport sink (
		input  valid, operation, process_index, resource_index, amount,
		output ready
	);
endinterface

`default_nettype wire

/* hdl/dd_out_if.sv */
// ---------------------------------------------------------------------------
// dd_out_if: result channel of the deadlock detector
// Valid/ready channel carrying one detection result per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface dd_out_if;
	logic                       valid;
	logic                       ready;
	logic [dd_pkg::MASK_W-1:0]  finished_mask;
	logic [dd_pkg::DEAD_W-1:0]  deadlocked_count;

	modport source (
		output valid, finished_mask, deadlocked_count,
		input  ready
	);
	modport sink (
		input  valid, finished_mask, deadlocked_count,
		output ready
	);
endinterface

`default_nettype wire

/* hdl/dd_ram.sv */
// ---------------------------------------------------------------------------
// dd_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module dd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/dd_seq.sv */
// ---------------------------------------------------------------------------
// dd_seq: microcode sequencer of the deadlock detector
// Step counter over the control program, jump condition select and
// gating of the control word onto the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module dd_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          out_free,
	input  wire dd_pkg::stat_t stat,
	output dd_pkg::ctrl_t      ctrl,
	output logic               busy
);

	dd_pkg::step_t  pc_q;
	logic           busy_q;
	dd_pkg::uword_t uw;
	logic           take;

	assign uw   = dd_pkg::ucode_rom(pc_q);
	assign busy = busy_q;

	always_comb begin
		case (uw.cond)
			dd_pkg::C_NEVER:      take = 1'b0;
			dd_pkg::C_NP_ZERO:    take = stat.np_zero;
			dd_pkg::C_FIN_P:      take = stat.fin_p;
			dd_pkg::C_NR_ZERO:    take = stat.nr_zero;
			dd_pkg::C_NOT_R_LAST: take = !stat.r_last;
			dd_pkg::C_NOT_FITS:   take = !stat.fits;
			dd_pkg::C_NOT_P_LAST: take = !stat.p_last;
			dd_pkg::C_CHANGED:    take = stat.changed;
			default:              take = 1'b0;
		endcase
	end

	always_comb begin
		ctrl.run_init   = busy_q & uw.run_init;
		ctrl.pass_start = busy_q & uw.pass_start;
		ctrl.proc_start = busy_q & uw.proc_start;
		ctrl.r_clr      = busy_q & uw.r_clr;
		ctrl.chk        = busy_q & uw.chk;
		ctrl.rel        = busy_q & uw.rel;
		ctrl.mark       = busy_q & uw.mark;
		ctrl.p_inc      = busy_q & uw.p_inc;
		ctrl.done       = busy_q & uw.done & out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= dd_pkg::ST_INIT;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q   <= dd_pkg::ST_INIT;
			end
		end else if (uw.done) begin
			// hold on the final step until the result register frees up
			if (out_free) begin
				busy_q <= 1'b0;
			end
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + dd_pkg::STEP_W'(1);
		end
	end

endmodule

`default_nettype wire

/* hdl/dd_datapath.sv */
// ---------------------------------------------------------------------------
// dd_datapath: storage and arithmetic of the deadlock detector
// Configuration registers, available vector, matrix memories, counters,
// finished flags and the fit / saturating release arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

module dd_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire dd_pkg::ctrl_t                   ctrl,
	input  wire dd_pkg::load_t                   load,
	input  wire logic                            cfg_we,
	input  wire logic [dd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [dd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output dd_pkg::stat_t                        stat
);

	logic [dd_pkg::PCNT_W-1:0]       process_count_q;
	logic [dd_pkg::RCNT_W-1:0]       resource_count_q;
	logic [dd_pkg::NP_W-1:0]         np;
	logic [dd_pkg::NR_W-1:0]         nr;

	logic [dd_pkg::AMOUNT_WIDTH-1:0] avail_q [dd_pkg::MAX_RESOURCES];
	logic [dd_pkg::P_IDX_W-1:0]      p_q;
	logic [dd_pkg::R_IDX_W-1:0]      r_q;
	logic                            fits_q;
	logic                            changed_q;
	logic [dd_pkg::MAX_PROCESSES-1:0] fin_q;
	logic [dd_pkg::NP_W-1:0]         fin_cnt_q;

	logic [dd_pkg::AMOUNT_WIDTH-1:0] alloc_rd;
	logic [dd_pkg::AMOUNT_WIDTH-1:0] req_rd;
	logic [dd_pkg::AMOUNT_WIDTH:0]   have;
	logic                            fit_r;
	logic [dd_pkg::AMOUNT_WIDTH-1:0] sat;
	logic [dd_pkg::ADDR_W-1:0]       raddr;
	logic [dd_pkg::ADDR_W-1:0]       waddr;

	assign raddr = {p_q, r_q};
	assign waddr = {load.p, load.r};

	dd_ram #(
		.WIDTH (dd_pkg::AMOUNT_WIDTH),
		.DEPTH (dd_pkg::DEPTH)
	) u_alloc_ram (
		.clk   (clk),
		.we    (load.en_alloc),
		.waddr (waddr),
		.wdata (load.amt),
		.raddr (raddr),
		.rdata (alloc_rd)
	);

	dd_ram #(
		.WIDTH (dd_pkg::AMOUNT_WIDTH),
		.DEPTH (dd_pkg::DEPTH)
	) u_req_ram (
		.clk   (clk),
		.we    (load.en_req),
		.waddr (waddr),
		.wdata (load.amt),
		.raddr (raddr),
		.rdata (req_rd)
	);

	// counts above the array bounds saturate
	assign np = (process_count_q > dd_pkg::PCNT_W'(dd_pkg::MAX_PROCESSES)) ?
		dd_pkg::NP_W'(dd_pkg::MAX_PROCESSES) : dd_pkg::NP_W'(process_count_q);
	assign nr = (resource_count_q > dd_pkg::RCNT_W'(dd_pkg::MAX_RESOURCES)) ?
		dd_pkg::NR_W'(dd_pkg::MAX_RESOURCES) : dd_pkg::NR_W'(resource_count_q);

	assign have  = {1'b0, avail_q[r_q]} + {1'b0, alloc_rd};
	assign fit_r = have >= {1'b0, req_rd};
	assign sat   = have[dd_pkg::AMOUNT_WIDTH] ? '1 : have[dd_pkg::AMOUNT_WIDTH-1:0];

	always_comb begin
		stat.np_zero = (np == '0);
		stat.nr_zero = (nr == '0);
		stat.fin_p   = fin_q[p_q];
		stat.r_last  = (dd_pkg::NR_W'(r_q) == nr - dd_pkg::NR_W'(1));
		stat.p_last  = (dd_pkg::NP_W'(p_q) == np - dd_pkg::NP_W'(1));
		stat.fits    = fits_q;
		stat.changed = changed_q;
		stat.mask    = dd_pkg::MASK_W'(fin_q);
		stat.dead    = dd_pkg::DEAD_W'(np - fin_cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q  <= dd_pkg::PCNT_W'(dd_pkg::MAX_PROCESSES);
			resource_count_q <= dd_pkg::RCNT_W'(dd_pkg::MAX_RESOURCES);
		end else if (cfg_we) begin
			case (cfg_index)
				dd_pkg::CFG_PROCESS_COUNT:  process_count_q  <= cfg_data[dd_pkg::PCNT_W-1:0];
				dd_pkg::CFG_RESOURCE_COUNT: resource_count_q <= cfg_data[dd_pkg::RCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dd_pkg::MAX_RESOURCES; i++) begin
				avail_q[i] <= '0;
			end
		end else if (load.en_avail) begin
			avail_q[load.r] <= load.amt;
		end else if (ctrl.rel) begin
			avail_q[r_q] <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q       <= '0;
			r_q       <= '0;
			fits_q    <= 1'b0;
			changed_q <= 1'b0;
			fin_q     <= '0;
			fin_cnt_q <= '0;
		end else begin
			if (ctrl.run_init) begin
				fin_q     <= '0;
				fin_cnt_q <= '0;
			end
			if (ctrl.pass_start) begin
				p_q       <= '0;
				changed_q <= 1'b0;
			end
			if (ctrl.proc_start) begin
				r_q    <= '0;
				fits_q <= 1'b1;
			end
			if (ctrl.r_clr) begin
				r_q <= '0;
			end
			if (ctrl.chk) begin
				fits_q <= fits_q & fit_r;
				r_q    <= r_q + dd_pkg::R_IDX_W'(1);
			end
			if (ctrl.rel) begin
				r_q <= r_q + dd_pkg::R_IDX_W'(1);
			end
			if (ctrl.mark) begin
				fin_q[p_q] <= 1'b1;
				fin_cnt_q  <= fin_cnt_q + dd_pkg::NP_W'(1);
				changed_q  <= 1'b1;
			end
			if (ctrl.p_inc) begin
				p_q <= p_q + dd_pkg::P_IDX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/deadlock_detection_unit.sv */
// ---------------------------------------------------------------------------
// deadlock_detection_unit: resource deadlock detector
// Load items fill the available vector and the allocation / request
// matrices; a run item finds which processes can finish and returns
// the finished mask and the deadlocked process count.
// ---------------------------------------------------------------------------
// usage
//   item channel: operation 0/1/2 writes available / allocation / request
//   at (process_index, resource_index); operation 3 starts a detection run.
//   load items produce no result; item.ready stays high between runs,
//   so loads can stream at one transfer per cycle.
//   a run drops item.ready while the microcode program walks the matrices:
//   per pass, a finished process is skipped, a blocked one has every
//   resource checked, and one that fits is checked, then releases every
//   resource and is marked; the run takes at most process_count + 1 passes.
//   every matrix access is two steps because the memories have a
//   registered read port; that sets the per-resource cost.
//   the result sits in an output register; if the receiver stalls, the
//   program waits on its last step, and item.ready returns once the
//   result has been taken into that register.
//   configuration: cfg_we with cfg_index 0 = process count, 1 = resource
//   count, to be written only while no run is in flight; the block does
//   not enforce this. reset clears available and the finished flags and
//   sets the counts (16 and 8); matrix entries hold no value until written.
// ---------------------------------------------------------------------------
`default_nettype none

module deadlock_detection_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dd_pkg::CFG_DATA_W-1:0]  cfg_data,
	dd_in_if.sink                               item,
	dd_out_if.source                            result
);

	dd_pkg::ctrl_t ctrl;
	dd_pkg::stat_t stat;
	dd_pkg::load_t load;
	logic          busy;
	logic          accept;
	logic          start;
	logic          out_free;

	logic                      res_valid_q;
	logic [dd_pkg::MASK_W-1:0] mask_q;
	logic [dd_pkg::DEAD_W-1:0] dead_q;

	// item side: loads go straight into storage, a run kicks the sequencer
	assign item.ready = !busy;
	assign accept     = item.valid & item.ready;
	assign start      = accept && (item.operation == dd_pkg::OP_RUN);

	always_comb begin
		load.en_avail = accept && (item.operation == dd_pkg::OP_WR_AVAIL);
		load.en_alloc = accept && (item.operation == dd_pkg::OP_WR_ALLOC);
		load.en_req   = accept && (item.operation == dd_pkg::OP_WR_REQ);
		load.p        = item.process_index[dd_pkg::P_IDX_W-1:0];
		load.r        = item.resource_index[dd_pkg::R_IDX_W-1:0];
		load.amt      = item.amount[dd_pkg::AMOUNT_WIDTH-1:0];
	end

	// result register is free when empty or being drained this cycle
	assign out_free = !res_valid_q || result.ready;

	dd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.stat     (stat),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	dd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.load      (load),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat)
	);

	// output register: loaded on the final program step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.done) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.done) begin
			mask_q <= stat.mask;
			dead_q <= stat.dead;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.finished_mask    = mask_q;
	assign result.deadlocked_count = dead_q;

endmodule

`default_nettype wire

/* bench/deadlock_detection_checker.sv */
// ---------------------------------------------------------------------------
// deadlock_detection_checker: result predictor and comparator
// Mirrors the available vector, the allocation / request matrices and the
// count registers from the observed transfers and configuration writes,
// works out the finished mask and deadlocked count of every run item and
// compares each result transfer against the oldest outstanding verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module deadlock_detection_checker
	import dd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	dd_in_if                           item,
	dd_out_if                          result,
	output int                         errors,
	output int                         pending,
	output int                         checked
);

	localparam int MAX_REPORTS = 10;

	typedef logic [AMOUNT_WIDTH-1:0] amount_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [DEAD_W-1:0] dead;
	} verdict_t;

	amount_t           avail [MAX_RESOURCES];
	amount_t           alloc [MAX_PROCESSES][MAX_RESOURCES];
	amount_t           req   [MAX_PROCESSES][MAX_RESOURCES];
	logic [PCNT_W-1:0] proc_count;
	logic [RCNT_W-1:0] res_count;
	verdict_t          expected_verdicts [$];
	verdict_t          want;

	// repeated passes until nothing changes; releases saturate
	function automatic verdict_t detect_deadlock();
		int                       np;
		int                       nr;
		logic [MAX_PROCESSES-1:0] finished;
		logic                     progress;
		logic                     fits;
		logic [AMOUNT_WIDTH:0]    have;
		verdict_t                 v;
		np = (proc_count > MAX_PROCESSES) ? MAX_PROCESSES : int'(proc_count);
		nr = (res_count > MAX_RESOURCES) ? MAX_RESOURCES : int'(res_count);
		finished = '0;
		do begin
			progress = 1'b0;
			for (int p = 0; p < np; p++) begin
				if (!finished[p]) begin
					fits = 1'b1;
					for (int r = 0; r < nr; r++) begin
						have = {1'b0, avail[r]} + {1'b0, alloc[p][r]};
						if (have < {1'b0, req[p][r]})
							fits = 1'b0;
					end
					if (fits) begin
						for (int r = 0; r < nr; r++) begin
							have = {1'b0, avail[r]} + {1'b0, alloc[p][r]};
							avail[r] = have[AMOUNT_WIDTH] ? '1 : have[AMOUNT_WIDTH-1:0];
						end
						finished[p] = 1'b1;
						progress = 1'b1;
					end
				end
			end
		end while (progress);
		v = '0;
		for (int p = 0; p < np; p++) begin
			if (finished[p])
				v.mask[p] = 1'b1;
			else
				v.dead = v.dead + 1'b1;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (avail[r])
				avail[r] = '0;
			foreach (alloc[p, r]) begin
				alloc[p][r] = '0;
				req[p][r]   = '0;
			end
			proc_count = PCNT_W'(MAX_PROCESSES);
			res_count  = RCNT_W'(MAX_RESOURCES);
			expected_verdicts.delete();
			errors  = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PROCESS_COUNT:  proc_count = cfg_data[PCNT_W-1:0];
					CFG_RESOURCE_COUNT: res_count  = cfg_data[RCNT_W-1:0];
					default: ;
				endcase
			end
			// compare before queueing, so a run taken this cycle is not matched
			if (result.valid && result.ready) begin
				checked++;
				if (expected_verdicts.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result: mask %h deadlocked %0d",
							result.finished_mask, result.deadlocked_count);
				end else begin
					want = expected_verdicts.pop_front();
					if (result.finished_mask !== want.mask ||
							result.deadlocked_count !== want.dead) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("result %0d: mask %h deadlocked %0d, expected mask %h deadlocked %0d",
								checked, result.finished_mask, result.deadlocked_count,
								want.mask, want.dead);
					end
				end
			end
			if (item.valid && item.ready) begin
				case (op_t'(item.operation))
					OP_WR_AVAIL: avail[item.resource_index] = item.amount;
					OP_WR_ALLOC: alloc[item.process_index][item.resource_index] = item.amount;
					OP_WR_REQ:   req[item.process_index][item.resource_index] = item.amount;
					OP_RUN:      expected_verdicts.push_back(detect_deadlock());
					default: ;
				endcase
			end
			pending = expected_verdicts.size();
		end
	end

endmodule

`default_nettype wire

/* bench/deadlock_detection_unit_tb.sv */
// ---------------------------------------------------------------------------
// deadlock_detection_unit_tb: testbench top of the deadlock detector
// Preloads every matrix entry, runs a short directed set (corner amounts,
// zero and out-of-range counts, saturating releases) and then random
// load / run sequences over many count settings, with random idling on
// both channels, a long result hold-off and a drained pause.
// ---------------------------------------------------------------------------
`default_nettype none

module deadlock_detection_unit_tb;
	import dd_pkg::*;

	localparam int HOLD_CYCLES    = 300;    // result channel hold-off
	localparam int SETTLE_CYCLES  = 8;      // quiet time before a count write
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 125;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dd_in_if  item_ch ();
	dd_out_if result_ch ();

	int errors;
	int pending;
	int checked;
	int items_sent;
	int settings_done;
	int hold_req;
	int proc_span;   // processes in use, for aiming writes
	int res_span;    // resources in use, for aiming writes
	bit send_gaps;
	bit take_gaps;

	deadlock_detection_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	deadlock_detection_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly small amounts so runs mix finishing and blocked processes,
	// with some full-range and near-maximum values to hit saturation
	function automatic logic [AMT_FLD_W-1:0] pick_amount();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return AMT_FLD_W'($urandom_range(0, 7));
		else if (roll < 75)
			return AMT_FLD_W'($urandom_range(0, 255));
		else if (roll < 88)
			return AMT_FLD_W'($urandom);
		else if (roll < 96)
			return AMT_FLD_W'(65535 - $urandom_range(0, 3));
		return '0;
	endfunction

	// one item transfer; inputs change on the falling edge only
	task automatic send(input op_t op, input int p, input int r,
			input logic [AMT_FLD_W-1:0] amt);
		@(negedge clk);
		while (send_gaps && $urandom_range(0, 99) < 33) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.operation      <= op;
		item_ch.process_index  <= PIDX_FLD_W'(p);
		item_ch.resource_index <= RIDX_FLD_W'(r);
		item_ch.amount         <= amt;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	// drop valid and hold until every run has delivered its result
	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both count registers, written only with the block idle
	task automatic set_counts(input int procs, input int res);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PROCESS_COUNT;
		cfg_data  <= CFG_DATA_W'(procs);
		@(negedge clk);
		cfg_index <= CFG_RESOURCE_COUNT;
		cfg_data  <= CFG_DATA_W'(res);
		@(negedge clk);
		cfg_we <= 1'b0;
		// zero or out-of-range counts still aim writes over the full arrays
		proc_span = ((procs & 31) == 0 || (procs & 31) > MAX_PROCESSES) ?
			MAX_PROCESSES : (procs & 31);
		res_span = ((res & 15) == 0 || (res & 15) > MAX_RESOURCES) ?
			MAX_RESOURCES : (res & 15);
		settings_done++;
	endtask

	// a handful of loads mostly inside the rows and columns in use,
	// some stray writes anywhere, then a run
	task automatic detection_scenario();
		int writes;
		int roll;
		writes = $urandom_range(1, 12);
		repeat (writes) begin
			roll = $urandom_range(0, 99);
			if (roll < 15)
				send(OP_WR_AVAIL, $urandom_range(0, 15), $urandom_range(0, res_span - 1),
					pick_amount());
			else if (roll < 55)
				send(OP_WR_ALLOC, $urandom_range(0, proc_span - 1),
					$urandom_range(0, res_span - 1), pick_amount());
			else if (roll < 92)
				send(OP_WR_REQ, $urandom_range(0, proc_span - 1),
					$urandom_range(0, res_span - 1), pick_amount());
			else
				send(op_t'(OP_W'($urandom_range(0, 2))), $urandom_range(0, 15),
					$urandom_range(0, 7), AMT_FLD_W'($urandom));
		end
		// index and amount fields of a run carry no meaning
		send(OP_RUN, $urandom_range(0, 15), $urandom_range(0, 7), AMT_FLD_W'($urandom));
	endtask

	// result receiver: random idling, or a long hold-off on request
	initial begin
		int hold_seen;
		hold_seen = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_ch.ready <= !take_gaps || ($urandom_range(0, 99) >= 33);
			end
		end
	end

	// watchdog: counts cycles in which neither channel moves a transfer
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: %0d cycles without a transfer", WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int  target;
		int  pc;
		int  rc;
		int  roll;
		bit  paused;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_PROCESS_COUNT;
		cfg_data               = '0;
		item_ch.valid          = 1'b0;
		item_ch.operation      = OP_WR_AVAIL;
		item_ch.process_index  = '0;
		item_ch.resource_index = '0;
		item_ch.amount         = '0;
		send_gaps              = 1'b1;
		take_gaps              = 1'b1;
		hold_req               = 0;
		items_sent             = 0;
		settings_done          = 0;
		proc_span              = MAX_PROCESSES;
		res_span               = MAX_RESOURCES;
		paused                 = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every matrix entry gets a value before any run can read it
		for (int p = 0; p < MAX_PROCESSES; p++) begin
			for (int r = 0; r < MAX_RESOURCES; r++) begin
				send(OP_WR_ALLOC, p, r, pick_amount());
				send(OP_WR_REQ, p, r, pick_amount());
			end
		end
		for (int r = 0; r < MAX_RESOURCES; r++)
			send(OP_WR_AVAIL, $urandom_range(0, 15), r, pick_amount());

		// directed: reset counts of 16 processes and 8 resources
		send(OP_RUN, 0, 0, '0);
		// largest amounts at the far corners; releases saturate
		send(OP_WR_AVAIL, 0, 7, '1);
		send(OP_WR_ALLOC, 15, 7, '1);
		send(OP_WR_REQ, 15, 7, '1);
		send(OP_WR_AVAIL, 15, 0, '0);
		send(OP_WR_REQ, 0, 0, '1);
		send(OP_RUN, 15, 7, '1);
		// no reload: this run starts from the sums the last one left behind
		send(OP_RUN, 0, 0, '0);
		// zero processes, zero resources, then counts above the array bounds
		set_counts(0, 8);
		send(OP_RUN, 0, 0, '0);
		set_counts(16, 0);
		send(OP_RUN, 0, 0, '0);
		set_counts(31, 15);
		send(OP_RUN, 0, 0, '0);
		// single process and resource, saturating release
		set_counts(1, 1);
		send(OP_WR_ALLOC, 0, 0, '1);
		send(OP_WR_AVAIL, 0, 0, '1);
		send(OP_WR_REQ, 0, 0, '1);
		send(OP_RUN, 0, 0, '0);
		// resource count data with the upper bit set keeps only the low bits
		set_counts(17, 24);
		send(OP_RUN, 0, 0, '0);

		// random phases, each under its own count setting
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				pc = MAX_PROCESSES;
				rc = MAX_RESOURCES;
			end else if (ph == PHASES - 1) begin
				pc = 1;
				rc = 1;
			end else begin
				// mostly few processes to keep runs short
				roll = $urandom_range(0, 99);
				if (roll < 50)
					pc = $urandom_range(1, 6);
				else if (roll < 85)
					pc = $urandom_range(7, MAX_PROCESSES);
				else
					pc = $urandom_range(0, 31);
				rc = ($urandom_range(0, 99) < 70) ? $urandom_range(1, MAX_RESOURCES) :
					$urandom_range(0, 31);
			end
			set_counts(pc, rc);
			// one phase runs with no idling on either side
			send_gaps = (ph != 3);
			take_gaps = (ph != 3);
			target = items_sent + PHASE_ITEMS;
			if (ph == 1) begin
				// receiver holds off while loads pile up behind a finished run
				hold_req++;
				send(OP_RUN, 0, 0, '0);
				repeat (3) detection_scenario();
			end
			while (items_sent < target) begin
				detection_scenario();
				// sender stops once until every run has reported
				if (ph == 5 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end

		// all stimulus taken: drain the results, then let the block settle
		wait_drained();
		repeat (20) @(posedge clk);
		if (pending != 0)
			$display("%0d detection results never arrived", pending);
		$display("covered %0d item transfers, %0d detection results, %0d count settings",
			items_sent, checked, settings_done);
		$display("zero and out-of-range counts, saturating releases, result hold-off, no-idle stretch");
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
